// ----- rtl/token_value_type_classifier_unit_defines.svh -----
// Assertion macros shared by the token value type classifier RTL.
`ifndef TOKEN_VALUE_TYPE_CLASSIFIER_UNIT_DEFINES_SVH
`define TOKEN_VALUE_TYPE_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TVTC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TVTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tvtc_pkg.sv -----
// Package: constants, types and scanner functions of the token value type classifier.
package tvtc_pkg;

    localparam int CH_W    = 8;
    localparam int TDATA_W = 8;
    localparam int CODE_W  = 3;
    localparam int FS_W    = 5;
    localparam int IS_W    = 2;
    localparam int CNT_W   = 2;

    // Float scanner states
    localparam logic [FS_W-1:0] FS_START = 5'd0;
    localparam logic [FS_W-1:0] FS_SIGN  = 5'd1;
    localparam logic [FS_W-1:0] FS_DINT  = 5'd2;
    localparam logic [FS_W-1:0] FS_DDOT  = 5'd3;
    localparam logic [FS_W-1:0] FS_DFRAC = 5'd4;
    localparam logic [FS_W-1:0] FS_DEXP  = 5'd5;
    localparam logic [FS_W-1:0] FS_DEXPS = 5'd6;
    localparam logic [FS_W-1:0] FS_DEXPD = 5'd7;
    localparam logic [FS_W-1:0] FS_ZERO  = 5'd8;
    localparam logic [FS_W-1:0] FS_HX    = 5'd9;
    localparam logic [FS_W-1:0] FS_HINT  = 5'd10;
    localparam logic [FS_W-1:0] FS_HDOT  = 5'd11;
    localparam logic [FS_W-1:0] FS_HFRAC = 5'd12;
    localparam logic [FS_W-1:0] FS_HEXP  = 5'd13;
    localparam logic [FS_W-1:0] FS_HEXPS = 5'd14;
    localparam logic [FS_W-1:0] FS_HEXPD = 5'd15;
    localparam logic [FS_W-1:0] FS_INF1  = 5'd16;
    localparam logic [FS_W-1:0] FS_INF3  = 5'd18;
    localparam logic [FS_W-1:0] FS_INF7  = 5'd22;
    localparam logic [FS_W-1:0] FS_INF8  = 5'd23;
    localparam logic [FS_W-1:0] FS_NAN1  = 5'd24;
    localparam logic [FS_W-1:0] FS_NAN2  = 5'd25;
    localparam logic [FS_W-1:0] FS_NAN3  = 5'd26;
    localparam logic [FS_W-1:0] FS_NANP  = 5'd27;
    localparam logic [FS_W-1:0] FS_NANC  = 5'd28;
    localparam logic [FS_W-1:0] FS_DEAD  = 5'd29;

    // Integer scanner states
    localparam logic [IS_W-1:0] IS_START = 2'd0;
    localparam logic [IS_W-1:0] IS_SIGN  = 2'd1;
    localparam logic [IS_W-1:0] IS_DIGS  = 2'd2;
    localparam logic [IS_W-1:0] IS_DEAD  = 2'd3;

    // Result type codes
    localparam logic [CODE_W-1:0] TC_EMPTY    = 3'd0;
    localparam logic [CODE_W-1:0] TC_DOT      = 3'd1;
    localparam logic [CODE_W-1:0] TC_QUESTION = 3'd2;
    localparam logic [CODE_W-1:0] TC_BOOLEAN  = 3'd3;
    localparam logic [CODE_W-1:0] TC_INTEGER  = 3'd4;
    localparam logic [CODE_W-1:0] TC_FLOAT    = 3'd5;
    localparam logic [CODE_W-1:0] TC_CHAR     = 3'd6;
    localparam logic [CODE_W-1:0] TC_STRING   = 3'd7;

    // Character constants
    localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CH_W-1:0] CH_QMARK  = 8'h3F;
    localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_W-1:0] CH_ONE    = 8'h31;
    localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CH_W-1:0] CH_USCORE = 8'h5F;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_TILDE  = 8'h7E;
    localparam logic [CH_W-1:0] CH_CASE   = 8'h20;

    // Scanner view of the token including the current character
    typedef struct packed {
        logic [FS_W-1:0] fs;
        logic [IS_W-1:0] is;
        logic            single;
        logic [CH_W-1:0] first;
    } scan_t;

    function automatic logic is_dig(input logic [CH_W-1:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [CH_W-1:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_hex(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] l;
        l = c | CH_CASE;
        return is_dig(c) || (l inside {[8'h61:8'h66]});
    endfunction

    function automatic logic is_sign(input logic [CH_W-1:0] c);
        return c inside {CH_PLUS, CH_MINUS};
    endfunction

    function automatic logic is_space(input logic [CH_W-1:0] c);
        return c inside {CH_SPACE, [8'h09:8'h0D]};
    endfunction

    function automatic logic [FS_W-1:0] mantissa_start(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] l;
        l = c | CH_CASE;
        if (c == CH_ZERO)
            return FS_ZERO;
        else if (is_dig(c))
            return FS_DINT;
        else if (c == CH_DOT)
            return FS_DDOT;
        else if (is_alpha(c) && l == 8'h69)
            return FS_INF1;
        else if (is_alpha(c) && l == 8'h6E)
            return FS_NAN1;
        else
            return FS_DEAD;
    endfunction

    // Letter wanted after each partial "infinity" state
    function automatic logic [CH_W-1:0] inf_char(input logic [FS_W-1:0] s);
        case (s)
            5'd16:   return 8'h6E; // n
            5'd17:   return 8'h66; // f
            5'd18:   return 8'h69; // i
            5'd19:   return 8'h6E; // n
            5'd20:   return 8'h69; // i
            5'd21:   return 8'h74; // t
            5'd22:   return 8'h79; // y
            default: return 8'hFF;
        endcase
    endfunction

    function automatic logic [FS_W-1:0] float_next(input logic [FS_W-1:0] s,
                                                   input logic [CH_W-1:0] c);
        logic [CH_W-1:0] l;
        logic [FS_W-1:0] n;
        l = is_alpha(c) ? (c | CH_CASE) : 8'h00;
        n = FS_DEAD;
        case (s)
            FS_START:
                if (is_space(c))     n = FS_START;
                else if (is_sign(c)) n = FS_SIGN;
                else                 n = mantissa_start(c);
            FS_SIGN:
                n = mantissa_start(c);
            FS_ZERO, FS_DINT:
                if (s == FS_ZERO && l == 8'h78) n = FS_HX;
                else if (is_dig(c))             n = FS_DINT;
                else if (c == CH_DOT)           n = FS_DFRAC;
                else if (l == 8'h65)            n = FS_DEXP;
            FS_DDOT:
                if (is_dig(c)) n = FS_DFRAC;
            FS_DFRAC:
                if (is_dig(c))       n = FS_DFRAC;
                else if (l == 8'h65) n = FS_DEXP;
            FS_DEXP:
                if (is_sign(c))     n = FS_DEXPS;
                else if (is_dig(c)) n = FS_DEXPD;
            FS_DEXPS, FS_DEXPD:
                if (is_dig(c)) n = FS_DEXPD;
            FS_HX:
                if (is_hex(c))        n = FS_HINT;
                else if (c == CH_DOT) n = FS_HDOT;
            FS_HINT:
                if (is_hex(c))        n = FS_HINT;
                else if (c == CH_DOT) n = FS_HFRAC;
                else if (l == 8'h70)  n = FS_HEXP;
            FS_HDOT:
                if (is_hex(c)) n = FS_HFRAC;
            FS_HFRAC:
                if (is_hex(c))       n = FS_HFRAC;
                else if (l == 8'h70) n = FS_HEXP;
            FS_HEXP:
                if (is_sign(c))     n = FS_HEXPS;
                else if (is_dig(c)) n = FS_HEXPD;
            FS_HEXPS, FS_HEXPD:
                if (is_dig(c)) n = FS_HEXPD;
            FS_NAN1:
                if (l == 8'h61) n = FS_NAN2;
            FS_NAN2:
                if (l == 8'h6E) n = FS_NAN3;
            FS_NAN3:
                if (c == CH_LPAREN) n = FS_NANP;
            FS_NANP:
                if (is_dig(c) || is_alpha(c) || c == CH_USCORE) n = FS_NANP;
                else if (c == CH_RPAREN)                        n = FS_NANC;
            default:
                if ((s inside {[FS_INF1:FS_INF7]}) && l == inf_char(s))
                    n = s + 5'd1;
        endcase
        return n;
    endfunction

    function automatic logic float_accepts(input logic [FS_W-1:0] s);
        return s inside {FS_ZERO, FS_DINT, FS_DFRAC, FS_DEXPD, FS_HINT, FS_HFRAC,
                         FS_HEXPD, FS_INF3, FS_INF8, FS_NAN3, FS_NANC};
    endfunction

    function automatic logic [IS_W-1:0] int_next(input logic [IS_W-1:0] s,
                                                 input logic [CH_W-1:0] c);
        logic [IS_W-1:0] n;
        n = IS_DEAD;
        case (s)
            IS_START:
                if (is_sign(c))     n = IS_SIGN;
                else if (is_dig(c)) n = IS_DIGS;
            IS_SIGN, IS_DIGS:
                if (is_dig(c)) n = IS_DIGS;
            default:
                n = IS_DEAD;
        endcase
        return n;
    endfunction

endpackage

// ----- rtl/tvtc_scan.sv -----
// Per-token scanner: float and integer DFAs, length counter and first byte.
module tvtc_scan (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [tvtc_pkg::CH_W-1:0] ch,
    input  logic                     last,
    input  logic                     empty_req,
    output tvtc_pkg::scan_t          scan
);
    import tvtc_pkg::*;

    logic [FS_W-1:0]  fs_reg;
    logic [FS_W-1:0]  fs_next;
    logic [IS_W-1:0]  is_reg;
    logic [IS_W-1:0]  is_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CH_W-1:0]  first_reg;
    logic [CH_W-1:0]  first_next;

    always_comb
    begin
        fs_next    = float_next(fs_reg, ch);
        is_next    = int_next(is_reg, ch);
        first_next = (count_reg == 2'd0) ? ch : first_reg;
        count_next = (count_reg == 2'd2) ? count_reg : count_reg + 2'd1;
    end

    assign scan.fs     = fs_next;
    assign scan.is     = is_next;
    assign scan.single = (count_reg == 2'd0);
    assign scan.first  = first_next;

    // Return to start of token after every result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg    <= FS_START;
            is_reg    <= IS_START;
            count_reg <= '0;
            first_reg <= '0;
        end
        else if (step)
        begin
            if (last || empty_req)
            begin
                fs_reg    <= FS_START;
                is_reg    <= IS_START;
                count_reg <= '0;
                first_reg <= '0;
            end
            else
            begin
                fs_reg    <= fs_next;
                is_reg    <= is_next;
                count_reg <= count_next;
                first_reg <= first_next;
            end
        end
    end

endmodule

// ----- rtl/tvtc_classify.sv -----
// Priority classifier: turns the scanner view of a finished token into a type code.
module tvtc_classify (
    input  tvtc_pkg::scan_t              scan,
    input  logic                         empty_req,
    output logic [tvtc_pkg::CODE_W-1:0]  type_code
);
    import tvtc_pkg::*;

    always_comb
    begin
        if (empty_req)
            type_code = TC_EMPTY;
        else if (scan.single && scan.first == CH_DOT)
            type_code = TC_DOT;
        else if (scan.single && scan.first == CH_QMARK)
            type_code = TC_QUESTION;
        else if (scan.single && (scan.first inside {CH_ZERO, CH_ONE}))
            type_code = TC_BOOLEAN;
        else if (scan.is == IS_DIGS)
            type_code = TC_INTEGER;
        else if (float_accepts(scan.fs))
            type_code = TC_FLOAT;
        else if (scan.single && (scan.first inside {[CH_SPACE:CH_TILDE]}))
            type_code = TC_CHAR;
        else
            type_code = TC_STRING;
    end

endmodule

// ----- rtl/token_value_type_classifier_unit.sv -----
// Top level of the token value type classifier: input register, scanner, result register.
// Path: a final or empty item is accepted into the input register, and its type code
// goes through the scanner DFA into the result register, which drives m_tvalid.
// Throughput: one item per cycle unless a final item waits on a full result register.
// Reset (rst_n low, asynchronous): both valid flags drop and the scanner returns to the
// start of a token.
module token_value_type_classifier_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tvtc_pkg::TDATA_W-1:0]   s_tdata,   // [7:0] ch
    input  logic                           s_tlast,   // last
    input  logic                           s_tuser,   // [0] empty_req
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tvtc_pkg::TDATA_W-1:0]   m_tdata    // [2:0] type_code, [7:3] zero
);
    import tvtc_pkg::*;

    `include "token_value_type_classifier_unit_defines.svh"

    // Input register
    logic                in_valid_reg;
    logic [CH_W-1:0]     in_ch_reg;
    logic                in_last_reg;
    logic                in_empty_reg;

    // Result register
    logic                out_valid_reg;
    logic [CODE_W-1:0]   out_code_reg;
    logic [CODE_W-1:0]   code_next;

    logic                emits;
    logic                out_free;
    logic                advance;
    scan_t               scan;

    // An item without a result never waits on the output side; one that ends a token
    // advances only when the result register is free or being emptied this cycle.
    assign emits    = in_last_reg || in_empty_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!emits || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // Hold the payload until the item moves on
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_ch_reg    <= s_tdata[CH_W-1:0];
            in_last_reg  <= s_tlast;
            in_empty_reg <= s_tuser;
        end
    end

    tvtc_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .ch        (in_ch_reg),
        .last      (in_last_reg),
        .empty_req (in_empty_reg),
        .scan      (scan)
    );

    tvtc_classify u_classify (
        .scan      (scan),
        .empty_req (in_empty_reg),
        .type_code (code_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && emits)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emits)
            out_code_reg <= code_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W-CODE_W){1'b0}}, out_code_reg};

    // Checks on the block's own control
    `TVTC_ASSERT_NEXT(a_empty_gives_code, advance && in_empty_reg,
        m_tvalid && m_tdata[2:0] == TC_EMPTY, "empty item did not yield the empty code")
    `TVTC_ASSERT_NEXT(a_no_invented_result, advance && !emits,
        m_tvalid == $past(m_tvalid && !m_tready), "result appeared without a final item")
    `TVTC_ASSERT_SAME(a_ready_when_free, !m_tvalid, s_tready,
        "input stalled although the result register is free")

endmodule
